>>> rtl/one_euro_filter_core_assert.svh
// Assertion macros used by the one euro filter checker.
`ifndef ONE_EURO_FILTER_CORE_ASSERT_SVH
`define ONE_EURO_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define OEF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("one_euro_filter_core check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define OEF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("one_euro_filter_core check failed");

`endif

>>> rtl/oef_pkg.sv
// Shared types, register indexes and arithmetic helpers for the one euro filter.
package oef_pkg;

  localparam logic [31:0] INV_2PI_Q32 = 32'd683565276;
  localparam logic [31:0] ALPHA_ONE   = 32'h8000_0000;

  localparam int unsigned IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_UPDATE_RATE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_CUTOFF    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CUTOFF_SLOPE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DERIV_CUTOFF  = 3'd4;

  typedef struct packed {
    logic [31:0] update_rate;
    logic [31:0] min_cutoff;
    logic [31:0] cutoff_slope;
    logic [31:0] deriv_cutoff;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic active;
    logic clear;
  } lane_ctrl_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // prev + sign(d) * floor(|d| * alpha / 2^31)
  function automatic logic signed [31:0] blend(input logic signed [31:0] prev,
                                               input logic signed [32:0] d,
                                               input logic [31:0]        alpha);
    logic [32:0]        mag;
    logic [64:0]        prod;
    logic [33:0]        step;
    logic signed [33:0] base;
    logic signed [33:0] r;
    mag  = mag33(d);
    prod = 65'(mag) * 65'(alpha);
    step = prod[64:31];
    base = $signed({{2{prev[31]}}, prev});
    r    = d[32] ? (base - $signed(step)) : (base + $signed(step));
    return r[31:0];
  endfunction

endpackage

>>> rtl/oef_div.sv
// Iterative restoring divider, two quotient bits per cycle, for alpha.
module oef_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [31:0] quo
);
  import oef_pkg::*;

  logic        busy;
  logic [3:0]  cnt;
  logic [32:0] rem;
  logic [32:0] dreg;
  logic [31:0] nbits;
  logic [31:0] q;
  logic        zden;

  logic [33:0] r_a;
  logic [33:0] r_b;
  logic [32:0] rem_a;
  logic [32:0] rem_b;
  logic        q_a;
  logic        q_b;

  always_comb begin
    r_a   = {rem, nbits[31]};
    q_a   = r_a >= {1'b0, dreg};
    rem_a = q_a ? 33'(r_a - {1'b0, dreg}) : r_a[32:0];
    r_b   = {rem_a, nbits[30]};
    q_b   = r_b >= {1'b0, dreg};
    rem_b = q_b ? 33'(r_b - {1'b0, dreg}) : r_b[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {2'b00, num[31:1]};
      nbits <= {num[0], 31'd0};
      dreg  <= den;
      zden  <= (den == 33'd0);
    end else if (busy) begin
      rem   <= rem_b;
      nbits <= {nbits[29:0], 2'b00};
      q     <= {q[29:0], q_a, q_b};
    end
  end

  assign quo = zden ? ALPHA_ONE : q;

endmodule

>>> rtl/oef_lane.sv
// One filter lane: derivative, smoothing, adaptive cutoff and value blend.
module oef_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  oef_pkg::lane_ctrl_t ctrl,
  input  oef_pkg::cfg_t      cfg,
  input  logic signed [31:0] sample,
  output logic               done,
  output logic signed [31:0] result
);
  import oef_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_SLOPE,
    ST_PREP_D,
    ST_DIV_D,
    ST_BLEND_D,
    ST_CUTOFF,
    ST_PREP_C,
    ST_DIV_C,
    ST_BLEND_V
  } state_t;

  state_t             state;
  logic               en;
  logic               primed;
  logic signed [31:0] last_value;
  logic signed [31:0] last_slope;
  logic signed [31:0] x;
  logic [31:0]        rt;
  logic signed [32:0] d1;
  logic signed [31:0] dx;
  logic signed [32:0] d2;
  logic signed [31:0] edx;
  logic [31:0]        cut;

  logic [63:0]        rt_prod;
  logic [32:0]        mag1;
  logic [64:0]        p1;
  logic signed [31:0] dx_sat;
  logic [31:0]        mag_e;
  logic [63:0]        pc;
  logic [64:0]        cut_sum;
  logic [31:0]        cut_next;
  logic signed [31:0] edx_next;
  logic signed [31:0] out_next;
  logic               div_start;
  logic [31:0]        div_num;
  logic [32:0]        div_den;
  logic               div_done;
  logic [31:0]        div_quo;

  always_comb begin
    rt_prod = 64'(cfg.update_rate) * 64'(INV_2PI_Q32);
    mag1    = mag33(d1);
    p1      = (65'(mag1) * 65'(cfg.update_rate)) >> FRAC_BITS;
    if (d1[32]) begin
      dx_sat = (p1 >= 65'h0_8000_0000) ? 32'sh8000_0000 : 32'(-p1[31:0]);
    end else begin
      dx_sat = (p1 > 65'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : p1[31:0];
    end
    edx_next = blend(last_slope, d2, div_quo);
    mag_e    = edx[31] ? 32'(-edx) : edx;
    pc       = (64'(cfg.cutoff_slope) * 64'(mag_e)) >> FRAC_BITS;
    cut_sum  = 65'(cfg.min_cutoff) + 65'(pc);
    cut_next = (cut_sum > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : cut_sum[31:0];
    out_next = primed ? blend(last_value, d1, div_quo) : x;
    div_start = (state == ST_PREP_D) || (state == ST_PREP_C);
    div_num   = (state == ST_PREP_D) ? cfg.deriv_cutoff : cut;
    div_den   = 33'(rt) + 33'(div_num);
  end

  oef_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      en         <= 1'b0;
      primed     <= 1'b0;
      last_value <= '0;
      last_slope <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (ctrl.start) begin
            en    <= ctrl.active;
            x     <= sample;
            state <= ST_RATE;
          end
        end
        ST_RATE: begin
          rt    <= rt_prod[63:32];
          d1    <= $signed({x[31], x}) - $signed({last_value[31], last_value});
          state <= ST_SLOPE;
        end
        ST_SLOPE: begin
          dx    <= primed ? dx_sat : 32'sd0;
          state <= ST_PREP_D;
        end
        ST_PREP_D: begin
          d2    <= $signed({dx[31], dx}) - $signed({last_slope[31], last_slope});
          state <= ST_DIV_D;
        end
        ST_DIV_D: begin
          if (div_done) begin
            state <= ST_BLEND_D;
          end
        end
        ST_BLEND_D: begin
          edx   <= primed ? edx_next : 32'sd0;
          state <= ST_CUTOFF;
        end
        ST_CUTOFF: begin
          cut   <= cut_next;
          state <= ST_PREP_C;
        end
        ST_PREP_C: begin
          state <= ST_DIV_C;
        end
        ST_DIV_C: begin
          if (div_done) begin
            state <= ST_BLEND_V;
          end
        end
        ST_BLEND_V: begin
          result <= out_next;
          done   <= 1'b1;
          if (en) begin
            last_value <= out_next;
            last_slope <= edx;
            primed     <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (ctrl.clear) begin
        primed <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/oef_merge.sv
// Output stage: collect lane results, zero inactive channels, hold until taken.
module oef_merge #(
  parameter int LANES = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               lanes_done,
  input  logic signed [31:0] res [LANES],
  input  logic [2:0]         act,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] filtered_x,
  output logic signed [31:0] filtered_y,
  output logic signed [31:0] filtered_z,
  output logic               loaded
);
  import oef_pkg::*;

  logic               pend;
  logic signed [31:0] vals [3];

  for (genvar i = 0; i < 3; i++) begin : g_ch
    if (i < LANES) begin : g_on
      assign vals[i] = act[i] ? res[i] : 32'sd0;
    end else begin : g_off
      assign vals[i] = 32'sd0;
    end
  end

  assign loaded = pend && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (lanes_done) begin
        pend <= 1'b1;
      end
      if (loaded) begin
        pend       <= 1'b0;
        out_valid  <= 1'b1;
        filtered_x <= vals[0];
        filtered_y <= vals[1];
        filtered_z <= vals[2];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/one_euro_filter_core.sv
// One euro filter core, up to three channels in parallel lanes, signed fixed point.
// A new transaction is taken only once the last result has moved to the output register.
// Processing time is dominated by the two alpha divisions (2 bits per cycle) in each lane.
// Output register holds a result while the next transaction is accepted and filtered.
// Reset (rst, synchronous): config and state regs reset, every channel awaits a first sample.
module one_euro_filter_core #(
  parameter int LANES     = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [oef_pkg::IDX_W-1:0] cfg_addr,
  input  logic [31:0]               cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        sample_x,
  input  logic signed [31:0]        sample_y,
  input  logic signed [31:0]        sample_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        filtered_x,
  output logic signed [31:0]        filtered_y,
  output logic signed [31:0]        filtered_z
);
  import oef_pkg::*;

  logic [1:0]         channel_count;
  cfg_t               cfg;
  logic               busy;
  logic [2:0]         act;
  logic [2:0]         act_next;
  logic [1:0]         cnt_lo;
  logic [1:0]         cnt_eff;
  logic               accept;
  logic               cfg_hit;
  logic               loaded;
  logic signed [31:0] smp [3];
  lane_ctrl_t         lane_ctrl [LANES];
  logic [LANES-1:0]   lane_done;
  logic signed [31:0] lane_res [LANES];

  assign smp[0] = sample_x;
  assign smp[1] = sample_y;
  assign smp[2] = sample_z;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_wr_en && (cfg_addr <= REG_DERIV_CUTOFF);

  always_comb begin
    cnt_lo  = (channel_count == 2'd0) ? 2'd1 : channel_count;
    cnt_eff = (cnt_lo > 2'(LANES)) ? 2'(LANES) : cnt_lo;
    for (int i = 0; i < 3; i++) begin
      act_next[i] = 2'(i) < cnt_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= 2'd3;
      cfg.update_rate  <= 32'(64'd30 << FRAC_BITS);
      cfg.min_cutoff   <= 32'(64'd1 << FRAC_BITS);
      cfg.cutoff_slope <= '0;
      cfg.deriv_cutoff <= 32'(64'd1 << FRAC_BITS);
      busy             <= 1'b0;
      act              <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_CHANNEL_COUNT: channel_count    <= cfg_wdata[1:0];
          REG_UPDATE_RATE:   cfg.update_rate  <= cfg_wdata;
          REG_MIN_CUTOFF:    cfg.min_cutoff   <= cfg_wdata;
          REG_CUTOFF_SLOPE:  cfg.cutoff_slope <= cfg_wdata;
          REG_DERIV_CUTOFF:  cfg.deriv_cutoff <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        busy <= 1'b1;
        act  <= act_next;
      end else if (loaded) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_ctrl[i] = '{start: accept, active: act_next[i], clear: cfg_hit};

    oef_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lane_ctrl[i]),
      .cfg    (cfg),
      .sample (smp[i]),
      .done   (lane_done[i]),
      .result (lane_res[i])
    );
  end

  oef_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .lanes_done (&lane_done),
    .res        (lane_res),
    .act        (act),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .filtered_x (filtered_x),
    .filtered_y (filtered_y),
    .filtered_z (filtered_z),
    .loaded     (loaded)
  );

endmodule

>>> rtl/oef_checker.sv
// Port-level checks for the one euro filter core, bound to the top level.
`include "one_euro_filter_core_assert.svh"

module oef_checker #(
  parameter int LANES = 3
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] filtered_x,
  input logic signed [31:0] filtered_y,
  input logic signed [31:0] filtered_z
);

  `OEF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered_x) && $stable(filtered_y) && $stable(filtered_z))
  `OEF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `OEF_ASSERT_IMPL(a_result_after_work, $rose(out_valid), $past(!in_ready))
  `OEF_ASSERT_IMPL(a_no_lane_y, out_valid, LANES >= 2 || filtered_y == 32'sd0)
  `OEF_ASSERT_IMPL(a_no_lane_z, out_valid, LANES >= 3 || filtered_z == 32'sd0)

endmodule

bind one_euro_filter_core oef_checker #(.LANES(LANES)) u_oef_checker (.*);
